// ===== rtl/oale_pkg.sv =====
// Shared types, operation and status codes for the ordered array list engine.
`default_nettype none

package oale_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 3;
	localparam int FPOS_W   = 4;
	localparam int COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND      = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_NAME  = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd4;
	localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

	typedef struct packed {
		logic [31:0]        score_word;
		logic signed [31:0] record_id;
		logic [31:0]        key_high;
		logic [63:0]        key_mid;
		logic [63:0]        key_low;
	} rec_t;

	typedef struct packed {
		logic               is_full;
		logic               is_empty;
		logic [COUNT_W-1:0] entry_count;
		logic [FPOS_W-1:0]  found_position;
		logic               found;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/oale_store.sv =====
// Record memory: one write port, one read port with registered read data.
`default_nettype none

module oale_store #(
	parameter int CAPACITY = oale_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire oale_pkg::rec_t wdata,
	input  wire logic [AW-1:0] raddr,
	output oale_pkg::rec_t     rdata
);
	import oale_pkg::*;

	rec_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/oale_seq.sv =====
// Operation sequencer: record count, scan and shift passes over the record memory.
`default_nettype none

module oale_seq #(
	parameter int CAPACITY = oale_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [oale_pkg::OP_W-1:0]    op_in,
	input  wire logic [oale_pkg::POS_W-1:0]   pos_in,
	input  wire oale_pkg::rec_t               rec_in,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output oale_pkg::res_t                    res,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output oale_pkg::rec_t                    mem_wdata,
	output logic [AW-1:0]                     mem_raddr,
	input  wire oale_pkg::rec_t               mem_rdata
);
	import oale_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SHDN = 3'd2;
	localparam logic [2:0] S_SHUP = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [POS_W-1:0]    pos_q;
	rec_t                rec_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic                more_q;
	logic                rv_q;
	logic [AW-1:0]       raddr_q;
	logic [AW-1:0]       put_q;
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	logic [AW-1:0]       where_q;

	logic          full_c;
	logic          empty_c;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] pos_w;
	logic          hit;
	logic          last;
	logic          rd_en;

	always_comb begin
		full_c  = (count_q == CW'(CAPACITY));
		empty_c = (count_q == '0);
		cnt_w   = WW'(count_q);
		pos_w   = WW'(pos_in);
		hit     = rv_q && (mem_rdata.key_low == rec_q.key_low) &&
			(mem_rdata.key_mid == rec_q.key_mid) && (mem_rdata.key_high == rec_q.key_high);
		last    = rv_q && (CW'(raddr_q) == (count_q - CW'(1)));
	end

	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_en = (ptr_q < count_q) && !hit;
			S_SHDN:  rd_en = (ptr_q < count_q);
			S_SHUP:  rd_en = more_q;
			default: rd_en = 1'b0;
		endcase
	end

	assign mem_raddr = ptr_q[AW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = put_q;
		mem_wdata = rec_q;
		unique case (state_q)
			S_SHDN: begin
				mem_we    = rv_q;
				mem_waddr = raddr_q - AW'(1);
				mem_wdata = mem_rdata;
			end
			S_SHUP: begin
				mem_we    = rv_q;
				mem_waddr = raddr_q + AW'(1);
				mem_wdata = mem_rdata;
			end
			S_PUT: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status         = status_q;
		res.found          = found_q;
		res.found_position = found_q ? FPOS_W'(where_q) : '0;
		res.entry_count    = COUNT_W'(count_q);
		res.is_empty       = empty_c;
		res.is_full        = full_c;
	end

	// read pipeline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else begin
			rv_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raddr_q <= ptr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			more_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= op_in;
						pos_q    <= pos_in;
						rec_q    <= rec_in;
						status_q <= ST_OK;
						found_q  <= 1'b0;
						where_q  <= '0;
						unique case (op_in)
							OP_APPEND: begin
								if (full_c) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									put_q   <= count_q[AW-1:0];
									state_q <= S_PUT;
								end
							end
							OP_INSERT: begin
								if (full_c) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else if (pos_w > cnt_w) begin
									status_q <= ST_BAD_POS;
									state_q  <= S_DONE;
								end else if (pos_w == cnt_w) begin
									put_q   <= count_q[AW-1:0];
									state_q <= S_PUT;
								end else begin
									ptr_q   <= count_q - CW'(1);
									more_q  <= 1'b1;
									state_q <= S_SHUP;
								end
							end
							OP_FIND, OP_DEL_NAME: begin
								if (empty_c) begin
									if (op_in == OP_DEL_NAME) begin
										status_q <= ST_EMPTY;
									end
									state_q <= S_DONE;
								end else begin
									ptr_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							OP_DEL_AT: begin
								if (empty_c) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else if (pos_w >= cnt_w) begin
									status_q <= ST_BAD_POS;
									state_q  <= S_DONE;
								end else begin
									ptr_q   <= CW'(pos_in) + CW'(1);
									state_q <= S_SHDN;
								end
							end
							OP_OVERWRITE: begin
								if (empty_c) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else if (pos_w >= cnt_w) begin
									status_q <= ST_BAD_POS;
									state_q  <= S_DONE;
								end else begin
									put_q   <= AW'(pos_in);
									state_q <= S_PUT;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (op_q == OP_FIND) begin
							found_q <= 1'b1;
							where_q <= raddr_q;
							state_q <= S_DONE;
						end else begin
							// close the gap from the slot after the match
							ptr_q   <= CW'(raddr_q) + CW'(1);
							state_q <= S_SHDN;
						end
					end else if (last) begin
						if (op_q == OP_DEL_NAME) begin
							status_q <= ST_NOT_FOUND;
						end
						state_q <= S_DONE;
					end else if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_SHDN: begin
					if (last || (!rv_q && (ptr_q >= count_q))) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				S_SHUP: begin
					if (rd_en) begin
						if (ptr_q == CW'(pos_q)) begin
							more_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q - CW'(1);
						end
					end
					if (rv_q && (raddr_q == AW'(pos_q))) begin
						put_q   <= raddr_q;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if ((op_q == OP_APPEND) || (op_q == OP_INSERT)) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: stream ports, sequencer, memory, output register.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | one operation on the list (tuser op, tdata args)
//  m_*     | out | m_tvalid/m_tready  | one result word per operation
//
// Sequencing: one operation is in work at a time; append and overwrite write their record
// in the put state before the result, and a rejected or ignored operation goes straight
// to the result. Find reads one record per cycle through the single memory read port.
// Insert and delete copy one record per cycle (read one slot, write its neighbor); a delete
// by name shifts only the records after its match. Worst case is a delete by name on a full
// list. Reset clears the record count and control state; memory contents need no clearing.
// A finished result sits in the output register while the next word is accepted; the
// sequencer holds its next result until that register drains.
`default_nettype none

module ordered_array_list_engine #(
	parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// operation[2:0]
	input  wire logic [2:0]   s_tuser,
	// position[4:0], key_bytes_low[68:5], key_bytes_mid[132:69], key_bytes_high[164:133],
	// record_id[196:165], score_word[228:197], zero fill[231:229]
	input  wire logic [231:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status[2:0], found[3], found_position[7:4], entry_count[12:8], is_empty[13],
	// is_full[14], zero fill[15]
	output logic [15:0]       m_tdata
);
	import oale_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	rec_t          rec_in;
	res_t          res;
	logic          res_valid;
	logic          res_ready;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	rec_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	rec_t          mem_rdata;
	logic          out_valid_q;
	res_t          out_q;

	// unpack the argument fields
	always_comb begin
		rec_in.key_low    = s_tdata[68:5];
		rec_in.key_mid    = s_tdata[132:69];
		rec_in.key_high   = s_tdata[164:133];
		rec_in.record_id  = s_tdata[196:165];
		rec_in.score_word = s_tdata[228:197];
	end

	oale_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op_in     (s_tuser),
		.pos_in    (s_tdata[4:0]),
		.rec_in    (rec_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	oale_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// the output register takes a new result when empty or being drained
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload while the sink stalls
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire
